/* rtl/core/pgad_pkg.sv */
// ----------------------------------------------------------------------------
// pgad_pkg
// Shared types, register codes and palette tables of the gray area downscaler.
// ----------------------------------------------------------------------------
package pgad_pkg;

	typedef struct packed {
		logic [7:0] palette_index;
		logic       frame_start;
	} pix_t;

	typedef struct packed {
		logic [7:0] gray_value;
		logic [7:0] out_col;
		logic [7:0] out_row;
		logic       frame_done;
	} res_t;

	typedef struct packed {
		logic [7:0] out_width;
		logic [7:0] out_height;
		logic [7:0] crop_left;
		logic [7:0] crop_top;
		logic [7:0] crop_width;
		logic [7:0] crop_height;
	} cfg_t;

	// placement of one output pixel inside the crop window
	typedef struct packed {
		logic [7:0] col;
		logic [7:0] row;
		logic       done;
	} tag_t;

	localparam logic [2:0] REG_OUT_WIDTH   = 3'd0;
	localparam logic [2:0] REG_OUT_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_CROP_LEFT   = 3'd2;
	localparam logic [2:0] REG_CROP_TOP    = 3'd3;
	localparam logic [2:0] REG_CROP_WIDTH  = 3'd4;
	localparam logic [2:0] REG_CROP_HEIGHT = 3'd5;

	localparam cfg_t CFG_RESET = '{
		out_width:   8'd84,
		out_height:  8'd110,
		crop_left:   8'd0,
		crop_top:    8'd0,
		crop_width:  8'd84,
		crop_height: 8'd84
	};

	typedef logic [23:0] rgb_lut_t [128];
	typedef logic [7:0]  gray_lut_t [128];

	localparam rgb_lut_t PAL_RGB = '{
		24'h000000,24'h4a4a4a,24'h6f6f6f,24'h8e8e8e,24'haaaaaa,24'hc0c0c0,24'hd6d6d6,24'hececec,
		24'h484800,24'h69690f,24'h86861d,24'ha2a22a,24'hbbbb35,24'hd2d240,24'he8e84a,24'hfcfc54,
		24'h7c2c00,24'h904811,24'ha26221,24'hb47a30,24'hc3903d,24'hd2a44a,24'hdfb755,24'hecc860,
		24'h901c00,24'ha33915,24'hb55328,24'hc66c3a,24'hd5824a,24'he39759,24'hf0aa67,24'hfcbc74,
		24'h940000,24'ha71a1a,24'hb83232,24'hc84848,24'hd65c5c,24'he46f6f,24'hf08080,24'hfc9090,
		24'h840064,24'h97197a,24'ha8308f,24'hb846a2,24'hc659b3,24'hd46cc3,24'he07cd2,24'hec8ce0,
		24'h500084,24'h68199a,24'h7d30ad,24'h9246c0,24'ha459d0,24'hb56ce0,24'hc57cee,24'hd48cfc,
		24'h140090,24'h331aa3,24'h4e32b5,24'h6848c6,24'h7f5cd5,24'h956fe3,24'ha980f0,24'hbc90fc,
		24'h000094,24'h181aa7,24'h2d32b8,24'h4248c8,24'h545cd6,24'h656fe4,24'h7580f0,24'h8490fc,
		24'h001c88,24'h183b9d,24'h2d57b0,24'h4272c2,24'h548ad2,24'h65a0e1,24'h75b5ef,24'h84c8fc,
		24'h003064,24'h185080,24'h2d6d98,24'h4288b0,24'h54a0c5,24'h65b7d9,24'h75cceb,24'h84e0fc,
		24'h004030,24'h18624e,24'h2d8169,24'h429e82,24'h54b899,24'h65d1ae,24'h75e7c2,24'h84fcd4,
		24'h004400,24'h1a661a,24'h328432,24'h48a048,24'h5cba5c,24'h6fd26f,24'h80e880,24'h90fc90,
		24'h143c00,24'h355f18,24'h527e2d,24'h6e9c42,24'h87b754,24'h9ed065,24'hb4e775,24'hc8fc84,
		24'h303800,24'h505916,24'h6d762b,24'h88923e,24'ha0ab4f,24'hb7c25f,24'hccd86e,24'he0ec7c,
		24'h482c00,24'h694d14,24'h866a26,24'ha28638,24'hbb9f47,24'hd2b656,24'he8cc63,24'hfce070
	};

	function automatic gray_lut_t build_gray_lut();
		gray_lut_t   lut;
		int unsigned r;
		int unsigned g;
		int unsigned b;
		for (int k = 0; k < 128; k++) begin
			r = int'(PAL_RGB[k][23:16]);
			g = int'(PAL_RGB[k][15:8]);
			b = int'(PAL_RGB[k][7:0]);
			lut[k] = 8'((21 * r + 72 * g + 7 * b) / 100);
		end
		return lut;
	endfunction

	localparam gray_lut_t GRAY_LUT = build_gray_lut();

endpackage

/* rtl/core/palette_gray_area_downscaler.sv */
// ----------------------------------------------------------------------------
// palette_gray_area_downscaler
// Palette to gray conversion and area-average resampling with a crop window.
// ----------------------------------------------------------------------------
// Source pixels enter on pix (valid/ready) in raster order, one palette code
// per item; frame_start restarts the position at the top left corner.
// Results leave on res (valid/ready), one item per finished output pixel
// inside the crop window, frame_done set on the last one of the frame.
// Size and crop registers sit behind the APB port; the user must write them
// only between items, and the block itself does not enforce this.
// An item is taken every cycle while res is not stalled; a result passes the
// stages s1 to s5 and then the output register once the source pixel that completes it is accepted.
// Row sums live in two banks of two-port memories, one per output row
// parity, with one read-modify-write per closed column segment in its row's bank
// and a carry write to the other; a write followed by a read of the same column is forwarded.
// When res is stalled the result waits in the output register and pixels
// keep flowing until the next result reaches the end of the pipeline.
// Reset restores the register defaults and puts the position at the frame
// start; the banks need no clearing, as the first source row of an output
// row overwrites its entries.
// ----------------------------------------------------------------------------
module palette_gray_area_downscaler #(
	parameter int IN_WIDTH      = 160,
	parameter int IN_HEIGHT     = 210,
	parameter int MAX_OUT_WIDTH = 160
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [4:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready,
	input  logic            pix_valid,
	output logic            pix_ready,
	input  pgad_pkg::pix_t  pix,
	output logic            res_valid,
	input  logic            res_ready,
	output pgad_pkg::res_t  res
);
	import pgad_pkg::*;

	localparam int WMAX  = (IN_WIDTH < MAX_OUT_WIDTH) ? IN_WIDTH : MAX_OUT_WIDTH;
	localparam int JW    = (WMAX > 1) ? $clog2(WMAX) : 1;
	localparam int OXW   = $clog2(WMAX + 1);
	localparam int OYW   = $clog2(IN_HEIGHT + 1);
	localparam int ACC_W = $clog2(IN_WIDTH * IN_HEIGHT * 255 + 1);

	cfg_t             cfg;
	logic             en;
	logic             v_s1, first_s1, close_s1, bank_s1, fresh_s1, emit_s1;
	logic [7:0]       code_s1;
	logic [OXW-1:0]   ox0_s1, ox1_s1;
	logic [JW-1:0]    j_s1;
	logic [OYW-1:0]   oy0_s1, oy1_s1;
	tag_t             tag_s1, tag_s4, tag_s5;
	logic             v_s4, v_s5;
	logic [ACC_W-1:0] sum_s4;
	logic [7:0]       gray_s5;
	logic             res_valid_q;
	res_t             res_q;

	assign en        = !(v_s5 && res_valid_q && !res_ready);
	assign pix_ready = en;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	pgad_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pgad_track #(
		.IN_WIDTH      (IN_WIDTH),
		.IN_HEIGHT     (IN_HEIGHT),
		.MAX_OUT_WIDTH (MAX_OUT_WIDTH)
	) u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.pix_valid (pix_valid),
		.pix       (pix),
		.cfg       (cfg),
		.v_s1      (v_s1),
		.code_s1   (code_s1),
		.first_s1  (first_s1),
		.close_s1  (close_s1),
		.ox0_s1    (ox0_s1),
		.ox1_s1    (ox1_s1),
		.j_s1      (j_s1),
		.oy0_s1    (oy0_s1),
		.oy1_s1    (oy1_s1),
		.bank_s1   (bank_s1),
		.fresh_s1  (fresh_s1),
		.emit_s1   (emit_s1),
		.tag_s1    (tag_s1)
	);

	pgad_accum #(
		.IN_WIDTH      (IN_WIDTH),
		.IN_HEIGHT     (IN_HEIGHT),
		.MAX_OUT_WIDTH (MAX_OUT_WIDTH)
	) u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_s1     (v_s1),
		.code_s1  (code_s1),
		.first_s1 (first_s1),
		.close_s1 (close_s1),
		.ox0_s1   (ox0_s1),
		.ox1_s1   (ox1_s1),
		.j_s1     (j_s1),
		.oy0_s1   (oy0_s1),
		.oy1_s1   (oy1_s1),
		.bank_s1  (bank_s1),
		.fresh_s1 (fresh_s1),
		.emit_s1  (emit_s1),
		.tag_s1   (tag_s1),
		.v_s4     (v_s4),
		.sum_s4   (sum_s4),
		.tag_s4   (tag_s4)
	);

	pgad_div #(
		.IN_WIDTH  (IN_WIDTH),
		.IN_HEIGHT (IN_HEIGHT)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_s4    (v_s4),
		.sum_s4  (sum_s4),
		.tag_s4  (tag_s4),
		.v_s5    (v_s5),
		.gray_s5 (gray_s5),
		.tag_s5  (tag_s5)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en && v_s5) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s5) begin
			res_q.gray_value <= gray_s5;
			res_q.out_col    <= tag_s5.col;
			res_q.out_row    <= tag_s5.row;
			res_q.frame_done <= tag_s5.done;
		end
	end

	// a result leaving the pipeline lands in the output register
	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && pix_ready) |=> (res_valid && (res.frame_done == $past(tag_s5.done))))
		else $error("result not loaded into output register");

	// a blocked result keeps the pipeline and the output register frozen
	assert property (@(posedge clk) disable iff (!arst_n)
		(!pix_ready) |=> ($stable(res) && v_s5))
		else $error("pipeline moved while result blocked");

	// frame start puts the tracker at the first column
	assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid && pix_ready && pix.frame_start) |=> (v_s1 && first_s1))
		else $error("frame start did not restart the position");

endmodule

/* rtl/core/pgad_cfg.sv */
// ----------------------------------------------------------------------------
// pgad_cfg
// APB register file holding resample size and crop window.
// ----------------------------------------------------------------------------
module pgad_cfg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [4:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready,
	output pgad_pkg::cfg_t  cfg
);
	import pgad_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign idx    = paddr[4:2];
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_OUT_WIDTH:   cfg_q.out_width   <= pwdata[7:0];
				REG_OUT_HEIGHT:  cfg_q.out_height  <= pwdata[7:0];
				REG_CROP_LEFT:   cfg_q.crop_left   <= pwdata[7:0];
				REG_CROP_TOP:    cfg_q.crop_top    <= pwdata[7:0];
				REG_CROP_WIDTH:  cfg_q.crop_width  <= pwdata[7:0];
				REG_CROP_HEIGHT: cfg_q.crop_height <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_OUT_WIDTH:   prdata = {24'd0, cfg_q.out_width};
			REG_OUT_HEIGHT:  prdata = {24'd0, cfg_q.out_height};
			REG_CROP_LEFT:   prdata = {24'd0, cfg_q.crop_left};
			REG_CROP_TOP:    prdata = {24'd0, cfg_q.crop_top};
			REG_CROP_WIDTH:  prdata = {24'd0, cfg_q.crop_width};
			REG_CROP_HEIGHT: prdata = {24'd0, cfg_q.crop_height};
			default:         prdata = 32'd0;
		endcase
	end

endmodule

/* rtl/core/pgad_track.sv */
// ----------------------------------------------------------------------------
// pgad_track
// Source position tracker: overlap spans, column and row closes, crop tags.
// ----------------------------------------------------------------------------
module pgad_track #(
	parameter int IN_WIDTH      = 160,
	parameter int IN_HEIGHT     = 210,
	parameter int MAX_OUT_WIDTH = 160,
	localparam int WMAX = (IN_WIDTH < MAX_OUT_WIDTH) ? IN_WIDTH : MAX_OUT_WIDTH,
	localparam int JW   = (WMAX > 1) ? $clog2(WMAX) : 1,
	localparam int OXW  = $clog2(WMAX + 1),
	localparam int OYW  = $clog2(IN_HEIGHT + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 pix_valid,
	input  pgad_pkg::pix_t       pix,
	input  pgad_pkg::cfg_t       cfg,
	output logic                 v_s1,
	output logic [7:0]           code_s1,
	output logic                 first_s1,
	output logic                 close_s1,
	output logic [OXW-1:0]       ox0_s1,
	output logic [OXW-1:0]       ox1_s1,
	output logic [JW-1:0]        j_s1,
	output logic [OYW-1:0]       oy0_s1,
	output logic [OYW-1:0]       oy1_s1,
	output logic                 bank_s1,
	output logic                 fresh_s1,
	output logic                 emit_s1,
	output pgad_pkg::tag_t       tag_s1
);
	import pgad_pkg::*;

	localparam int XW   = (IN_WIDTH > 1) ? $clog2(IN_WIDTH) : 1;
	localparam int YW   = (IN_HEIGHT > 1) ? $clog2(IN_HEIGHT) : 1;
	localparam int IXW  = (IN_HEIGHT > 1) ? $clog2(IN_HEIGHT) : 1;
	localparam int CPW  = $clog2(IN_WIDTH * WMAX + IN_WIDTH + 1);
	localparam int RPW  = $clog2(IN_HEIGHT * IN_HEIGHT + IN_HEIGHT + 1);
	localparam int MXW  = (IXW > JW) ? IXW : JW;
	localparam int CMPW = ((MXW > 8) ? MXW : 8) + 2;

	logic [XW-1:0]   x_q, x_c, x_n;
	logic [YW-1:0]   y_q, y_c, y_n;
	logic [JW-1:0]   j_q, j_c, j_n;
	logic [IXW-1:0]  i_q, i_c, i_n;
	logic [CPW-1:0]  xa_q, xa_c, xa_n, ja_q, ja_c, ja_n, xe;
	logic [RPW-1:0]  ya_q, ya_c, ya_n, ia_q, ia_c, ia_n, ye;
	logic [OXW-1:0]  ow, ox0, ox1;
	logic [OYW-1:0]  oh, oy0, oy1;
	logic            close, rowdone, fresh, in_crop, acc;
	logic [CMPW-1:0] ic, jc, top, bot, lft, rgt, endr, endc;
	tag_t            tag;

	assign acc = pix_valid && en;

	always_comb begin
		if (cfg.out_width == 8'd0) begin
			ow = OXW'(1);
		end else if (CMPW'(cfg.out_width) > CMPW'(WMAX)) begin
			ow = OXW'(WMAX);
		end else begin
			ow = OXW'(cfg.out_width);
		end
		if (cfg.out_height == 8'd0) begin
			oh = OYW'(1);
		end else if (CMPW'(cfg.out_height) > CMPW'(IN_HEIGHT)) begin
			oh = OYW'(IN_HEIGHT);
		end else begin
			oh = OYW'(cfg.out_height);
		end
	end

	always_comb begin
		x_c  = x_q;
		xa_c = xa_q;
		ja_c = ja_q;
		j_c  = j_q;
		y_c  = y_q;
		ya_c = ya_q;
		ia_c = ia_q;
		i_c  = i_q;
		if (pix.frame_start) begin
			x_c  = '0;
			xa_c = '0;
			ja_c = CPW'(IN_WIDTH);
			j_c  = '0;
			y_c  = '0;
			ya_c = '0;
			ia_c = RPW'(IN_HEIGHT);
			i_c  = '0;
		end
	end

	always_comb begin
		xe      = xa_c + CPW'(ow);
		close   = xe >= ja_c;
		ox0     = close ? OXW'(ja_c - xa_c) : ow;
		ox1     = (xe > ja_c) ? OXW'(xe - ja_c) : '0;
		ye      = ya_c + RPW'(oh);
		rowdone = ye >= ia_c;
		oy0     = rowdone ? OYW'(ia_c - ya_c) : oh;
		oy1     = (ye > ia_c) ? OYW'(ye - ia_c) : '0;
		fresh   = (ya_c + RPW'(IN_HEIGHT)) <= ia_c;
	end

	always_comb begin
		ic       = CMPW'(i_c);
		jc       = CMPW'(j_c);
		top      = CMPW'(cfg.crop_top);
		bot      = top + CMPW'(cfg.crop_height);
		lft      = CMPW'(cfg.crop_left);
		rgt      = lft + CMPW'(cfg.crop_width);
		endr     = (bot > CMPW'(oh)) ? CMPW'(oh) : bot;
		endc     = (rgt > CMPW'(ow)) ? CMPW'(ow) : rgt;
		in_crop  = (ic >= top) && (ic < bot) && (jc >= lft) && (jc < rgt);
		tag.col  = 8'(jc - lft);
		tag.row  = 8'(ic - top);
		tag.done = ((ic + CMPW'(1)) == endr) && ((jc + CMPW'(1)) == endc);
	end

	always_comb begin
		x_n  = x_c + XW'(1);
		xa_n = xe;
		ja_n = close ? ja_c + CPW'(IN_WIDTH) : ja_c;
		j_n  = close ? j_c + JW'(1) : j_c;
		y_n  = y_c;
		ya_n = ya_c;
		ia_n = ia_c;
		i_n  = i_c;
		if (x_c == XW'(IN_WIDTH - 1)) begin
			x_n  = '0;
			xa_n = '0;
			ja_n = CPW'(IN_WIDTH);
			j_n  = '0;
			if (y_c == YW'(IN_HEIGHT - 1)) begin
				y_n  = '0;
				ya_n = '0;
				ia_n = RPW'(IN_HEIGHT);
				i_n  = '0;
			end else begin
				y_n  = y_c + YW'(1);
				ya_n = ye;
				if (rowdone) begin
					ia_n = ia_c + RPW'(IN_HEIGHT);
					i_n  = i_c + IXW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q  <= '0;
			xa_q <= '0;
			ja_q <= CPW'(IN_WIDTH);
			j_q  <= '0;
			y_q  <= '0;
			ya_q <= '0;
			ia_q <= RPW'(IN_HEIGHT);
			i_q  <= '0;
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= pix_valid;
			if (acc) begin
				x_q  <= x_n;
				xa_q <= xa_n;
				ja_q <= ja_n;
				j_q  <= j_n;
				y_q  <= y_n;
				ya_q <= ya_n;
				ia_q <= ia_n;
				i_q  <= i_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			code_s1  <= pix.palette_index;
			first_s1 <= (x_c == '0);
			close_s1 <= close;
			ox0_s1   <= ox0;
			ox1_s1   <= ox1;
			j_s1     <= j_c;
			oy0_s1   <= oy0;
			oy1_s1   <= oy1;
			bank_s1  <= i_c[0];
			fresh_s1 <= fresh;
			emit_s1  <= close && rowdone && in_crop;
			tag_s1   <= tag;
		end
	end

endmodule

/* rtl/core/pgad_accum.sv */
// ----------------------------------------------------------------------------
// pgad_accum
// Column segment sums and read-modify-write of the two row banks.
// ----------------------------------------------------------------------------
module pgad_accum #(
	parameter int IN_WIDTH      = 160,
	parameter int IN_HEIGHT     = 210,
	parameter int MAX_OUT_WIDTH = 160,
	localparam int WMAX  = (IN_WIDTH < MAX_OUT_WIDTH) ? IN_WIDTH : MAX_OUT_WIDTH,
	localparam int JW    = (WMAX > 1) ? $clog2(WMAX) : 1,
	localparam int OXW   = $clog2(WMAX + 1),
	localparam int OYW   = $clog2(IN_HEIGHT + 1),
	localparam int ACC_W = $clog2(IN_WIDTH * IN_HEIGHT * 255 + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 v_s1,
	input  logic [7:0]           code_s1,
	input  logic                 first_s1,
	input  logic                 close_s1,
	input  logic [OXW-1:0]       ox0_s1,
	input  logic [OXW-1:0]       ox1_s1,
	input  logic [JW-1:0]        j_s1,
	input  logic [OYW-1:0]       oy0_s1,
	input  logic [OYW-1:0]       oy1_s1,
	input  logic                 bank_s1,
	input  logic                 fresh_s1,
	input  logic                 emit_s1,
	input  pgad_pkg::tag_t       tag_s1,
	output logic                 v_s4,
	output logic [ACC_W-1:0]     sum_s4,
	output pgad_pkg::tag_t       tag_s4
);
	import pgad_pkg::*;

	localparam int SW    = $clog2(IN_WIDTH * 255 + 1);

	logic [7:0]       g;
	logic [SW-1:0]    p0, p1, seg, seg_q;
	logic             v_s2, v_s3;
	logic [SW-1:0]    seg_s2;
	logic [OYW-1:0]   oy0_s2, oy1_s2;
	logic [JW-1:0]    j_s2, j_s3;
	logic             bank_s2, bank_s3, fresh_s2, fresh_s3, emit_s2, emit_s3, wb_s3;
	tag_t             tag_s2, tag_s3;
	logic [ACC_W-1:0] ma_s3, mb_s3;
	logic [ACC_W-1:0] mem0 [WMAX];
	logic [ACC_W-1:0] mem1 [WMAX];
	logic [ACC_W-1:0] rd0_q, rd1_q, wd0_q, wd1_q;
	logic [JW-1:0]    wa0_q, wa1_q;
	logic             wv0_q, wv1_q;
	logic [ACC_W-1:0] rdf0, rdf1, old_a, sum_a, wd0, wd1;
	logic             we0, we1;

	always_comb begin
		g   = code_s1[0] ? 8'd0 : GRAY_LUT[code_s1[7:1]];
		p0  = SW'(ox0_s1) * SW'(g);
		p1  = SW'(ox1_s1) * SW'(g);
		seg = (first_s1 ? '0 : seg_q) + p0;
	end

	always_ff @(posedge clk) begin
		if (en && v_s1) begin
			seg_q <= close_s1 ? p1 : seg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			wv0_q <= 1'b0;
			wv1_q <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1 && close_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3 && emit_s3;
			if (we0) begin
				wv0_q <= 1'b1;
			end
			if (we1) begin
				wv1_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s2   <= seg;
			oy0_s2   <= oy0_s1;
			oy1_s2   <= oy1_s1;
			j_s2     <= j_s1;
			bank_s2  <= bank_s1;
			fresh_s2 <= fresh_s1;
			emit_s2  <= emit_s1;
			tag_s2   <= tag_s1;
			ma_s3    <= ACC_W'(oy0_s2) * ACC_W'(seg_s2);
			mb_s3    <= ACC_W'(oy1_s2) * ACC_W'(seg_s2);
			wb_s3    <= (oy1_s2 != '0);
			j_s3     <= j_s2;
			bank_s3  <= bank_s2;
			fresh_s3 <= fresh_s2;
			emit_s3  <= emit_s2;
			tag_s3   <= tag_s2;
			sum_s4   <= sum_a;
			tag_s4   <= tag_s3;
		end
	end

	// last write of each bank forwarded over the read that missed it
	always_comb begin
		rdf0  = (wv0_q && (wa0_q == j_s3)) ? wd0_q : rd0_q;
		rdf1  = (wv1_q && (wa1_q == j_s3)) ? wd1_q : rd1_q;
		old_a = fresh_s3 ? '0 : (bank_s3 ? rdf1 : rdf0);
		sum_a = old_a + ma_s3;
		we0   = en && v_s3 && (!bank_s3 || wb_s3);
		we1   = en && v_s3 && (bank_s3 || wb_s3);
		wd0   = bank_s3 ? mb_s3 : sum_a;
		wd1   = bank_s3 ? sum_a : mb_s3;
	end

	always_ff @(posedge clk) begin
		if (we0) begin
			mem0[j_s3] <= wd0;
			wa0_q      <= j_s3;
			wd0_q      <= wd0;
		end
		if (en) begin
			rd0_q <= mem0[j_s2];
		end
	end

	always_ff @(posedge clk) begin
		if (we1) begin
			mem1[j_s3] <= wd1;
			wa1_q      <= j_s3;
			wd1_q      <= wd1;
		end
		if (en) begin
			rd1_q <= mem1[j_s2];
		end
	end

endmodule

/* rtl/core/pgad_div.sv */
// ----------------------------------------------------------------------------
// pgad_div
// Division of a finished sum by the frame area through a reciprocal multiply.
// ----------------------------------------------------------------------------
module pgad_div #(
	parameter int IN_WIDTH  = 160,
	parameter int IN_HEIGHT = 210,
	localparam int ACC_W = $clog2(IN_WIDTH * IN_HEIGHT * 255 + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 v_s4,
	input  logic [ACC_W-1:0]     sum_s4,
	input  pgad_pkg::tag_t       tag_s4,
	output logic                 v_s5,
	output logic [7:0]           gray_s5,
	output pgad_pkg::tag_t       tag_s5
);
	import pgad_pkg::*;

	localparam int AREA  = IN_WIDTH * IN_HEIGHT;
	localparam int DW    = $clog2(AREA);
	localparam int SH    = ACC_W + DW;
	localparam int MW    = ACC_W + 1;
	localparam longint unsigned RECIP = ((64'd1 << SH) + 64'(AREA) - 64'd1) / 64'(AREA);
	localparam logic [MW-1:0] MUL = MW'(RECIP);

	logic [ACC_W+MW-1:0] prod_s5;

	assign gray_s5 = prod_s5[SH +: 8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s5 <= (ACC_W + MW)'(sum_s4) * (ACC_W + MW)'(MUL);
			tag_s5  <= tag_s4;
		end
	end

endmodule
